>>> sv/stcd_pkg.sv
// ----------------------------------------------------------------------------
// stcd_pkg
// Types, constants and helper functions shared by the text command decoder.
// ----------------------------------------------------------------------------
package stcd_pkg;

    localparam int LINE_CAPACITY_DEF = 64;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [39:0] KW_HELP  = {"HELP", 8'h00};
    localparam logic [39:0] KW_START = "START";
    localparam logic [39:0] KW_STOP  = {"STOP", 8'h00};
    localparam logic [39:0] KW_SET   = {"SET", 16'h0000};
    localparam logic [39:0] KW_MODE  = {"MODE", 8'h00};

    localparam logic [15:0] VALUE_CAP  = 16'hFFFF;
    localparam logic [15:0] MELODY_MAX = 16'd255;
    localparam logic [15:0] MODE_MAX   = 16'd3;

    localparam logic [2:0] RPL_OK         = 3'd0;
    localparam logic [2:0] RPL_HELP       = 3'd1;
    localparam logic [2:0] RPL_MEL_RANGE  = 3'd2;
    localparam logic [2:0] RPL_SET_USAGE  = 3'd3;
    localparam logic [2:0] RPL_MODE_RANGE = 3'd4;
    localparam logic [2:0] RPL_MODE_USAGE = 3'd5;
    localparam logic [2:0] RPL_UNKNOWN    = 3'd6;
    localparam logic [2:0] RPL_TOO_LONG   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LONG,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_DIGIT,
        PH_END
    } phase_t;

    typedef struct packed {
        phase_t      ph;
        logic        neg;
        logic        any;
        logic [15:0] v;
    } parse_t;

    typedef struct packed {
        logic write_byte;
        logic clear_line;
        logic clear_flag;
        logic scan_start;
        logic scan_step;
        logic emit_long;
        logic emit_line;
    } cmd_t;

    typedef struct packed {
        logic is_eol;
        logic line_empty;
        logic line_full;
        logic text_empty;
        logic scan_done;
        logic out_free;
    } status_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic [7:0] up_case(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic logic [7:0] kw_byte(input logic [39:0] w, input logic [2:0] i);
        return w[(39 - 8 * int'(i)) -: 8];
    endfunction

    function automatic parse_t parse_init();
        parse_t p;
        p.ph  = PH_BLANK;
        p.neg = 1'b0;
        p.any = 1'b0;
        p.v   = '0;
        return p;
    endfunction

    function automatic parse_t parse_char(input parse_t p, input logic [7:0] c);
        parse_t      q;
        logic [19:0] t;
        q = p;
        t = ({4'b0, p.v} << 3) + ({4'b0, p.v} << 1) + {16'b0, c[3:0]};
        case (p.ph)
            PH_BLANK: begin
                if (is_blank(c)) begin
                    q.ph = PH_BLANK;
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    q.neg = (c == CH_MINUS);
                    q.ph  = PH_DIGIT;
                end else if (is_digit(c)) begin
                    q.v   = (t > {4'b0, VALUE_CAP}) ? VALUE_CAP : t[15:0];
                    q.any = 1'b1;
                    q.ph  = PH_DIGIT;
                end else begin
                    q.ph = PH_END;
                end
            end
            PH_DIGIT: begin
                if (is_digit(c)) begin
                    q.v   = (t > {4'b0, VALUE_CAP}) ? VALUE_CAP : t[15:0];
                    q.any = 1'b1;
                end else begin
                    q.ph = PH_END;
                end
            end
            default: q = p;
        endcase
        return q;
    endfunction

    function automatic logic [15:0] parse_value(input parse_t p);
        return (p.neg && p.v != '0) ? VALUE_CAP : p.v;
    endfunction

endpackage

>>> sv/stcd_ctrl.sv
// ----------------------------------------------------------------------------
// stcd_ctrl
// Controller: sequences byte intake, the line scan and result transfer.
// ----------------------------------------------------------------------------
module stcd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic              in_kind,
    output logic              in_ready,
    input  stcd_pkg::status_t sts,
    output stcd_pkg::cmd_t    cmd,
    output stcd_pkg::state_t  state
);

    stcd_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stcd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            stcd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_kind) begin
                        cmd.clear_flag = 1'b1;
                    end else if (sts.is_eol) begin
                        if (!sts.line_empty) begin
                            cmd.scan_start = 1'b1;
                            state_next     = stcd_pkg::ST_SCAN;
                        end
                    end else if (!sts.line_full) begin
                        cmd.write_byte = 1'b1;
                    end else begin
                        cmd.clear_line = 1'b1;
                        state_next     = stcd_pkg::ST_LONG;
                    end
                end
            end
            stcd_pkg::ST_LONG: begin
                if (sts.out_free) begin
                    cmd.emit_long = 1'b1;
                    state_next    = stcd_pkg::ST_IDLE;
                end
            end
            stcd_pkg::ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done) begin
                    state_next = stcd_pkg::ST_DONE;
                end
            end
            stcd_pkg::ST_DONE: begin
                if (sts.text_empty) begin
                    cmd.clear_line = 1'b1;
                    state_next     = stcd_pkg::ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit_line  = 1'b1;
                    cmd.clear_line = 1'b1;
                    state_next     = stcd_pkg::ST_IDLE;
                end
            end
            default: state_next = stcd_pkg::ST_IDLE;
        endcase
    end

    assign state = state_reg;

endmodule

>>> sv/stcd_dp.sv
// ----------------------------------------------------------------------------
// stcd_dp
// Datapath: line memory, trim tracking, keyword match, value parse, settings
// and the result register.
// ----------------------------------------------------------------------------
module stcd_dp #(
    parameter int LINE_CAPACITY = stcd_pkg::LINE_CAPACITY_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        in_byte,
    input  stcd_pkg::cmd_t    cmd,
    output stcd_pkg::status_t sts,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_reply,
    output logic              m_playing,
    output logic [7:0]        m_melody_num,
    output logic [1:0]        m_light_sel,
    output logic              m_new_command
);

    localparam int AW    = $clog2(LINE_CAPACITY);
    localparam int DEPTH = LINE_CAPACITY - 1;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    mem_q;

    logic [AW-1:0] len_reg;
    logic          zseen_reg;
    logic          nbseen_reg;
    logic [AW-1:0] start_reg;
    logic [AW-1:0] last_reg;
    logic [AW-1:0] text_len;

    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_cnt_reg;
    logic          pend_reg;
    logic [AW-1:0] pend_idx_reg;

    logic hlp_reg, sta_reg, sto_reg, setp_reg, setx_reg, modp_reg, modx_reg, qm_reg;
    stcd_pkg::parse_t set_prs_reg, mode_prs_reg;

    logic       play_reg;
    logic [7:0] melody_reg;
    logic [1:0] led_reg;
    logic       flag_reg;

    logic       m_valid_reg;
    logic [2:0] reply_reg;
    logic       out_play_reg;
    logic [7:0] out_mel_reg;
    logic [1:0] out_led_reg;
    logic       out_flag_reg;

    logic [7:0]  c;
    logic [7:0]  u;
    logic [15:0] set_val, mode_val;
    logic [2:0]  dec_reply;
    logic        dec_play;
    logic [7:0]  dec_mel;
    logic [1:0]  dec_led;
    logic        dec_flag;

    assign text_len = last_reg - start_reg;

    assign sts.is_eol     = (in_byte == stcd_pkg::CH_CR) || (in_byte == stcd_pkg::CH_LF);
    assign sts.line_empty = (len_reg == '0);
    assign sts.line_full  = (len_reg == AW'(DEPTH));
    assign sts.text_empty = !nbseen_reg;
    assign sts.scan_done  = (rd_cnt_reg == text_len) && !pend_reg;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.write_byte) begin
            mem[len_reg] <= in_byte;
        end
        mem_q <= mem[rd_ptr_reg];
    end

    // line length and trim bounds, tracked as bytes arrive
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            zseen_reg  <= 1'b0;
            nbseen_reg <= 1'b0;
            start_reg  <= '0;
            last_reg   <= '0;
        end else if (cmd.clear_line) begin
            len_reg    <= '0;
            zseen_reg  <= 1'b0;
            nbseen_reg <= 1'b0;
            start_reg  <= '0;
            last_reg   <= '0;
        end else if (cmd.write_byte) begin
            len_reg <= len_reg + 1'b1;
            if (!zseen_reg) begin
                if (in_byte == stcd_pkg::CH_NUL) begin
                    zseen_reg <= 1'b1;
                end else if (!stcd_pkg::is_blank(in_byte)) begin
                    if (!nbseen_reg) begin
                        start_reg <= len_reg;
                    end
                    nbseen_reg <= 1'b1;
                    last_reg   <= len_reg + 1'b1;
                end
            end
        end
    end

    // read pointer: one byte of the trimmed text per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            pend_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            pend_reg <= (rd_cnt_reg != text_len);
        end else begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            rd_ptr_reg <= start_reg;
            rd_cnt_reg <= '0;
        end else if (cmd.scan_step && rd_cnt_reg != text_len) begin
            rd_ptr_reg   <= rd_ptr_reg + 1'b1;
            rd_cnt_reg   <= rd_cnt_reg + 1'b1;
            pend_idx_reg <= rd_cnt_reg;
        end
    end

    assign c = mem_q;
    assign u = stcd_pkg::up_case(mem_q);

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            hlp_reg      <= 1'b1;
            sta_reg      <= 1'b1;
            sto_reg      <= 1'b1;
            setp_reg     <= 1'b1;
            setx_reg     <= 1'b1;
            modp_reg     <= 1'b1;
            modx_reg     <= 1'b1;
            qm_reg       <= 1'b0;
            set_prs_reg  <= stcd_pkg::parse_init();
            mode_prs_reg <= stcd_pkg::parse_init();
        end else if (pend_reg) begin
            if (pend_idx_reg < AW'(4)) begin
                hlp_reg  <= hlp_reg  && (u == stcd_pkg::kw_byte(stcd_pkg::KW_HELP,
                                                                 pend_idx_reg[2:0]));
                sto_reg  <= sto_reg  && (u == stcd_pkg::kw_byte(stcd_pkg::KW_STOP,
                                                                 pend_idx_reg[2:0]));
                modp_reg <= modp_reg && (u == stcd_pkg::kw_byte(stcd_pkg::KW_MODE,
                                                                 pend_idx_reg[2:0]));
                modx_reg <= modx_reg && (c == stcd_pkg::kw_byte(stcd_pkg::KW_MODE,
                                                                 pend_idx_reg[2:0]));
            end else begin
                mode_prs_reg <= stcd_pkg::parse_char(mode_prs_reg, c);
            end
            if (pend_idx_reg < AW'(5)) begin
                sta_reg <= sta_reg && (u == stcd_pkg::kw_byte(stcd_pkg::KW_START,
                                                               pend_idx_reg[2:0]));
            end
            if (pend_idx_reg < AW'(3)) begin
                setp_reg <= setp_reg && (u == stcd_pkg::kw_byte(stcd_pkg::KW_SET,
                                                                 pend_idx_reg[2:0]));
                setx_reg <= setx_reg && (c == stcd_pkg::kw_byte(stcd_pkg::KW_SET,
                                                                 pend_idx_reg[2:0]));
            end else begin
                set_prs_reg <= stcd_pkg::parse_char(set_prs_reg, c);
            end
            if (pend_idx_reg == '0) begin
                qm_reg <= (c == stcd_pkg::CH_QMARK);
            end
        end
    end

    assign set_val  = stcd_pkg::parse_value(set_prs_reg);
    assign mode_val = stcd_pkg::parse_value(mode_prs_reg);

    always_comb begin
        dec_reply = stcd_pkg::RPL_UNKNOWN;
        dec_play  = play_reg;
        dec_mel   = melody_reg;
        dec_led   = led_reg;
        dec_flag  = flag_reg;
        if ((text_len == AW'(4) && hlp_reg) || (text_len == AW'(1) && qm_reg)) begin
            dec_reply = stcd_pkg::RPL_HELP;
        end else if (text_len == AW'(5) && sta_reg) begin
            dec_reply = stcd_pkg::RPL_OK;
            dec_play  = 1'b1;
            dec_flag  = 1'b1;
        end else if (text_len == AW'(4) && sto_reg) begin
            dec_reply = stcd_pkg::RPL_OK;
            dec_play  = 1'b0;
            dec_flag  = 1'b1;
        end else if (text_len >= AW'(3) && setp_reg) begin
            if (!setx_reg || !set_prs_reg.any) begin
                dec_reply = stcd_pkg::RPL_SET_USAGE;
            end else if (set_val > stcd_pkg::MELODY_MAX) begin
                dec_reply = stcd_pkg::RPL_MEL_RANGE;
            end else begin
                dec_reply = stcd_pkg::RPL_OK;
                dec_mel   = set_val[7:0];
                dec_flag  = 1'b1;
            end
        end else if (text_len >= AW'(4) && modp_reg) begin
            if (!modx_reg || !mode_prs_reg.any) begin
                dec_reply = stcd_pkg::RPL_MODE_USAGE;
            end else if (mode_val > stcd_pkg::MODE_MAX) begin
                dec_reply = stcd_pkg::RPL_MODE_RANGE;
            end else begin
                dec_reply = stcd_pkg::RPL_OK;
                dec_led   = mode_val[1:0];
                dec_flag  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_reg   <= 1'b0;
            melody_reg <= '0;
            led_reg    <= '0;
            flag_reg   <= 1'b0;
        end else if (cmd.clear_flag) begin
            flag_reg <= 1'b0;
        end else if (cmd.emit_line) begin
            play_reg   <= dec_play;
            melody_reg <= dec_mel;
            led_reg    <= dec_led;
            flag_reg   <= dec_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_line || cmd.emit_long) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_line) begin
            reply_reg    <= dec_reply;
            out_play_reg <= dec_play;
            out_mel_reg  <= dec_mel;
            out_led_reg  <= dec_led;
            out_flag_reg <= dec_flag;
        end else if (cmd.emit_long) begin
            reply_reg    <= stcd_pkg::RPL_TOO_LONG;
            out_play_reg <= play_reg;
            out_mel_reg  <= melody_reg;
            out_led_reg  <= led_reg;
            out_flag_reg <= flag_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply       = reply_reg;
    assign m_playing     = out_play_reg;
    assign m_melody_num  = out_mel_reg;
    assign m_light_sel   = out_led_reg;
    assign m_new_command = out_flag_reg;

endmodule

>>> sv/serial_text_command_decoder.sv
// ----------------------------------------------------------------------------
// serial_text_command_decoder
// Collects received bytes into a line and decodes it as one text command.
// ----------------------------------------------------------------------------
// A byte that does not end a line is taken while idle. A CR or LF that ends
// a nonempty line starts a scan of the stored line through the single read
// port of the line memory, one byte a cycle, and no further byte is taken
// until the line is decoded and cleared. A line that is too long is cleared
// and answered with a too-long reply. A result waits in an output register;
// a new line end waits for it to be taken.
module serial_text_command_decoder #(
    parameter int LINE_CAPACITY = stcd_pkg::LINE_CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_byte_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_reply,
    output logic       m_playing,
    output logic [7:0] m_melody_num,
    output logic [1:0] m_light_sel,
    output logic       m_new_command
);

    stcd_pkg::cmd_t    cmd;
    stcd_pkg::status_t sts;
    stcd_pkg::state_t  state;

    stcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_kind  (s_kind),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    stcd_dp #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_byte       (s_byte_value),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reply       (m_reply),
        .m_playing     (m_playing),
        .m_melody_num  (m_melody_num),
        .m_light_sel   (m_light_sel),
        .m_new_command (m_new_command)
    );

    a_eol_scan : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_kind && sts.is_eol && !sts.line_empty)
        |=> (state == stcd_pkg::ST_SCAN))
        else $error("line end did not start a scan");

    a_long : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_kind && !sts.is_eol && sts.line_full)
        |=> (state == stcd_pkg::ST_LONG && sts.line_empty))
        else $error("overflow byte did not clear the line");

    a_emit_src : assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state) == stcd_pkg::ST_LONG
                            || $past(state) == stcd_pkg::ST_DONE))
        else $error("transfer raised outside a result state");

endmodule
